@@ hw/rtl/rational_bezier_plotter_defines.svh @@
// Assertion macros shared by the rational Bezier plotter RTL.
`ifndef RATIONAL_BEZIER_PLOTTER_DEFINES_SVH
`define RATIONAL_BEZIER_PLOTTER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RBP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RBP_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RBP_ASSERT(label, prop, msg)
`define RBP_NEVER(label, cond, msg)
`endif
`endif

@@ hw/rtl/rbp_pkg.sv @@
// Types, constants and command codes of the rational Bezier plotter.
`timescale 1ns / 1ps
`default_nettype none
package rbp_pkg;
  localparam int COORD_W        = 32;
  localparam int WEIGHT_W       = 16;
  localparam int SEG_W          = 6;
  localparam logic [SEG_W-1:0] SEG_RESET = 6'd16;
  localparam int MAX_POINTS_DEF = 16;
  localparam int BINOM_W        = 30;   // C(31,15) fits, enough for 32 points
  localparam int P_W            = 17;   // Q1.16 power term, up to 1.0
  localparam logic [P_W-1:0] ONE_Q16 = 17'h10000;
  localparam int C_W            = 32;
  localparam int OPND_W         = 33;
  localparam int PROD_W         = 66;
  localparam int ACC_W          = 64;
  localparam int DVD_W          = 64;
  localparam int DSR_W          = 32;
  localparam int QUO_W          = 32;
  localparam int MEM_W          = 3 * COORD_W + WEIGHT_W;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_PT, MUL_PU, MUL_BP, MUL_W, MUL_X, MUL_Y, MUL_Z
  } mul_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE, ACC_DEN, ACC_NX, ACC_NY, ACC_NZ
  } acc_sel_t;

  typedef enum logic [1:0] {
    DIV_T, DIV_X, DIV_Y, DIV_Z
  } div_sel_t;

  typedef struct packed {
    logic             wr_en;
    logic             rd_en;
    logic             bn_init;
    logic             bn_step;
    logic             div_start;
    div_sel_t         div_sel;
    logic             res_load;
    logic [SEG_W-1:0] i_idx;
    logic             p_init;
    logic             p_shift;
    mul_sel_t         mul_sel;
    acc_sel_t         acc_sel;
    logic             acc_clr;
    logic             out_load;
    logic             out_sample;
    logic             out_last;
    logic             out_trunc;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
  } status_t;
endpackage
`default_nettype wire

@@ hw/rtl/rbp_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle, low quotient bits kept.
`timescale 1ns / 1ps
`default_nettype none
module rbp_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [rbp_pkg::DVD_W-1:0] dividend,
  input  wire logic [rbp_pkg::DSR_W-1:0] divisor,
  output logic                           busy,
  output logic [rbp_pkg::QUO_W-1:0]      quotient
);
  localparam int CNT_W = $clog2(rbp_pkg::DVD_W);

  logic                      busy_r;
  logic [CNT_W-1:0]          cnt_r;
  logic [rbp_pkg::DVD_W-1:0] dvd_r;
  logic [rbp_pkg::DSR_W-1:0] dsr_r;
  logic [rbp_pkg::DSR_W-1:0] rem_r;
  logic [rbp_pkg::QUO_W-1:0] quo_r;
  logic [rbp_pkg::DSR_W:0]   trial;
  logic [rbp_pkg::DSR_W:0]   diff;
  logic                      qbit;

  assign trial = {rem_r, dvd_r[rbp_pkg::DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign qbit  = (trial >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      dvd_r  <= dividend;
      dsr_r  <= divisor;
      rem_r  <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[rbp_pkg::DVD_W-2:0], 1'b0};
      rem_r <= qbit ? diff[rbp_pkg::DSR_W-1:0] : trial[rbp_pkg::DSR_W-1:0];
      quo_r <= {quo_r[rbp_pkg::QUO_W-2:0], qbit};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(rbp_pkg::DVD_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;
endmodule
`default_nettype wire

@@ hw/rtl/rbp_datapath.sv @@
// Datapath: point store, binomial row, shared multiplier, accumulators, divider, output item.
`timescale 1ns / 1ps
`default_nettype none
module rbp_datapath #(
  parameter int MAX_POINTS = rbp_pkg::MAX_POINTS_DEF,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire rbp_pkg::cmd_t                  cmd,
  input  wire logic [AW-1:0]                  wr_addr,
  input  wire logic [AW-1:0]                  rd_addr,
  output rbp_pkg::status_t                    status,
  input  wire logic [rbp_pkg::SEG_W-1:0]      seg_count,
  input  wire logic [rbp_pkg::COORD_W-1:0]    in_x,
  input  wire logic [rbp_pkg::COORD_W-1:0]    in_y,
  input  wire logic [rbp_pkg::COORD_W-1:0]    in_z,
  input  wire logic [rbp_pkg::WEIGHT_W-1:0]   in_w,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [rbp_pkg::COORD_W-1:0]         out_x,
  output logic [rbp_pkg::COORD_W-1:0]         out_y,
  output logic [rbp_pkg::COORD_W-1:0]         out_z,
  output logic                                out_last,
  output logic                                out_trunc
);
  localparam int CW = rbp_pkg::COORD_W;

  logic [rbp_pkg::MEM_W-1:0]   mem_r [MAX_POINTS];
  logic [rbp_pkg::MEM_W-1:0]   rd_r;
  logic [rbp_pkg::BINOM_W-1:0] binom_r [MAX_POINTS];

  logic [15:0]                 t_r;
  logic [rbp_pkg::P_W-1:0]     u_r;
  logic [rbp_pkg::P_W-1:0]     p_r;
  logic [rbp_pkg::C_W-1:0]     c_r;
  logic [rbp_pkg::C_W-1:0]     den_r;
  logic [rbp_pkg::ACC_W-1:0]   nx_r, ny_r, nz_r;
  logic signed [rbp_pkg::PROD_W-1:0] prod_r;
  logic signed [rbp_pkg::PROD_W-1:0] prod_nxt;
  logic signed [rbp_pkg::OPND_W-1:0] mul_a, mul_b;
  logic [CW-1:0]               res_x_r, res_y_r, res_z_r;

  logic                        out_valid_r, out_last_r, out_trunc_r;
  logic [CW-1:0]               out_x_r, out_y_r, out_z_r;

  logic [CW-1:0]               rd_x, rd_y, rd_z;
  logic [rbp_pkg::WEIGHT_W-1:0] rd_w;

  logic [rbp_pkg::ACC_W-1:0]   num_sel;
  logic [rbp_pkg::DVD_W-1:0]   dvd;
  logic [rbp_pkg::DSR_W-1:0]   dsr;
  logic                        div_busy;
  logic [rbp_pkg::QUO_W-1:0]   quo;
  logic [CW-1:0]               quo_signed;

  assign rd_x = rd_r[CW-1:0];
  assign rd_y = rd_r[2*CW-1:CW];
  assign rd_z = rd_r[3*CW-1:2*CW];
  assign rd_w = rd_r[rbp_pkg::MEM_W-1:3*CW];

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= {in_w, in_z, in_y, in_x};
    end
    if (cmd.rd_en) begin
      rd_r <= mem_r[rd_addr];
    end
  end

  // Pascal's triangle, one row per step; entries above the degree stay zero.
  always_ff @(posedge clk) begin
    if (cmd.bn_init) begin
      for (int k = 0; k < MAX_POINTS; k++) begin
        binom_r[k] <= (k == 0) ? rbp_pkg::BINOM_W'(1) : '0;
      end
    end else if (cmd.bn_step) begin
      for (int k = 1; k < MAX_POINTS; k++) begin
        binom_r[k] <= binom_r[k] + binom_r[k-1];
      end
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      rbp_pkg::MUL_NONE: ;
      rbp_pkg::MUL_PT: begin
        mul_a = {16'b0, p_r};
        mul_b = {17'b0, t_r};
      end
      rbp_pkg::MUL_PU: begin
        mul_a = {16'b0, p_r};
        mul_b = {16'b0, u_r};
      end
      rbp_pkg::MUL_BP: begin
        mul_a = {3'b0, binom_r[rd_addr]};
        mul_b = {16'b0, p_r};
      end
      rbp_pkg::MUL_W: begin
        mul_a = {16'b0, prod_r[rbp_pkg::P_W-1:0]};
        mul_b = {17'b0, rd_w};
      end
      rbp_pkg::MUL_X: begin
        mul_a = {rd_x[CW-1], rd_x};
        mul_b = {1'b0, c_r};
      end
      rbp_pkg::MUL_Y: begin
        mul_a = {rd_y[CW-1], rd_y};
        mul_b = {1'b0, c_r};
      end
      rbp_pkg::MUL_Z: begin
        mul_a = {rd_z[CW-1], rd_z};
        mul_b = {1'b0, c_r};
      end
      default: ;
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_sel != rbp_pkg::MUL_NONE) begin
      prod_r <= prod_nxt;
    end
    if (cmd.p_init) begin
      p_r <= rbp_pkg::ONE_Q16;
    end else if (cmd.p_shift) begin
      p_r <= prod_r[rbp_pkg::P_W+15:16];
    end
  end

  // Products of coordinates wrap modulo 2^64 as the accumulation does.
  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      den_r <= '0;
      nx_r  <= '0;
      ny_r  <= '0;
      nz_r  <= '0;
    end else begin
      unique case (cmd.acc_sel)
        rbp_pkg::ACC_NONE: ;
        rbp_pkg::ACC_DEN: begin
          c_r   <= prod_r[rbp_pkg::C_W-1:0];
          den_r <= den_r + prod_r[rbp_pkg::C_W-1:0];
        end
        rbp_pkg::ACC_NX: nx_r <= nx_r + prod_r[rbp_pkg::ACC_W-1:0];
        rbp_pkg::ACC_NY: ny_r <= ny_r + prod_r[rbp_pkg::ACC_W-1:0];
        rbp_pkg::ACC_NZ: nz_r <= nz_r + prod_r[rbp_pkg::ACC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.div_sel)
      rbp_pkg::DIV_X: num_sel = nx_r;
      rbp_pkg::DIV_Y: num_sel = ny_r;
      rbp_pkg::DIV_Z: num_sel = nz_r;
      default:        num_sel = '0;
    endcase
    if (cmd.div_sel == rbp_pkg::DIV_T) begin
      dvd = {42'b0, cmd.i_idx, 16'b0};
      dsr = {26'b0, seg_count};
    end else begin
      dvd = num_sel[rbp_pkg::ACC_W-1] ? (~num_sel + 1'b1) : num_sel;
      dsr = den_r;
    end
  end

  rbp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dvd),
    .divisor  (dsr),
    .busy     (div_busy),
    .quotient (quo)
  );

  // Truncation toward zero: divide magnitudes, then restore the sign.
  assign quo_signed = num_sel[rbp_pkg::ACC_W-1] ? (~quo + 1'b1) : quo;

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      unique case (cmd.div_sel)
        rbp_pkg::DIV_T: begin
          t_r <= quo[15:0];
          u_r <= rbp_pkg::ONE_Q16 - {1'b0, quo[15:0]};
        end
        rbp_pkg::DIV_X: res_x_r <= quo_signed;
        rbp_pkg::DIV_Y: res_y_r <= quo_signed;
        rbp_pkg::DIV_Z: res_z_r <= quo_signed;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // A zero weight sum gives the origin.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_last_r  <= cmd.out_last;
      out_trunc_r <= cmd.out_trunc;
      if (!cmd.out_sample) begin
        out_x_r <= rd_x;
        out_y_r <= rd_y;
        out_z_r <= rd_z;
      end else if (den_r == '0) begin
        out_x_r <= '0;
        out_y_r <= '0;
        out_z_r <= '0;
      end else begin
        out_x_r <= res_x_r;
        out_y_r <= res_y_r;
        out_z_r <= res_z_r;
      end
    end
  end

  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid_r;

  assign out_valid = out_valid_r;
  assign out_x     = out_x_r;
  assign out_y     = out_y_r;
  assign out_z     = out_z_r;
  assign out_last  = out_last_r;
  assign out_trunc = out_trunc_r;
endmodule
`default_nettype wire

@@ hw/rtl/rbp_ctrl.sv @@
// Controller: point loading, plot sequencing over samples, points and power terms.
`timescale 1ns / 1ps
`default_nettype none
`include "rational_bezier_plotter_defines.svh"
module rbp_ctrl #(
  parameter int MAX_POINTS = rbp_pkg::MAX_POINTS_DEF,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int HW = $clog2(MAX_POINTS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic                      in_last,
  input  wire logic [rbp_pkg::SEG_W-1:0] seg_count,
  input  wire rbp_pkg::status_t          status,
  output rbp_pkg::cmd_t                  cmd,
  output logic [AW-1:0]                  wr_addr,
  output logic [AW-1:0]                  rd_addr
);
  typedef enum logic [4:0] {
    S_IDLE, S_PT_RD, S_PT_OUT, S_BN_INIT, S_BN_STEP, S_T_DIV, S_T_WAIT,
    S_J_RD, S_PT_MUL, S_PT_SH, S_PU_MUL, S_PU_SH, S_BP_MUL, S_W_MUL,
    S_C_ACC, S_X_MUL, S_Y_MUL, S_Z_MUL, S_Z_ACC, S_D_START, S_D_WAIT, S_S_OUT
  } state_t;

  state_t                   state_r, state_nxt;
  logic [HW-1:0]            held_r, held_nxt;
  logic                     ovf_r, ovf_nxt;
  logic [HW-1:0]            j_r, j_nxt;
  logic [HW-1:0]            s_r, s_nxt;
  logic [rbp_pkg::SEG_W-1:0] i_r, i_nxt;
  logic [HW-1:0]            pt_addr_r, pt_addr_nxt;
  logic                     pt_last_r, pt_last_nxt;
  logic                     short_r, short_nxt;
  rbp_pkg::div_sel_t        cs_r, cs_nxt;

  logic                     room;
  logic [HW-1:0]            held_after;
  logic [HW-1:0]            deg;
  logic [HW-1:0]            deg_left;

  assign room       = (held_r < HW'(MAX_POINTS));
  assign held_after = room ? held_r + 1'b1 : held_r;
  assign deg        = held_r - 1'b1;
  assign deg_left   = deg - j_r;

  assign in_ready = (state_r == S_IDLE);
  assign wr_addr  = held_r[AW-1:0];
  assign rd_addr  = (state_r == S_PT_RD || state_r == S_PT_OUT) ? pt_addr_r[AW-1:0]
                                                                 : j_r[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    held_nxt    = held_r;
    ovf_nxt     = ovf_r;
    j_nxt       = j_r;
    s_nxt       = s_r;
    i_nxt       = i_r;
    pt_addr_nxt = pt_addr_r;
    pt_last_nxt = pt_last_r;
    short_nxt   = short_r;
    cs_nxt      = cs_r;
    cmd         = '0;
    cmd.mul_sel = rbp_pkg::MUL_NONE;
    cmd.acc_sel = rbp_pkg::ACC_NONE;
    cmd.div_sel = rbp_pkg::DIV_T;
    cmd.i_idx   = i_r;
    cmd.out_trunc = ovf_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.wr_en = room;
          held_nxt  = held_after;
          ovf_nxt   = ovf_r | !room;
          if (in_last) begin
            if (held_after < HW'(2)) begin
              held_nxt = '0;
              ovf_nxt  = 1'b0;
            end else begin
              pt_addr_nxt = '0;
              pt_last_nxt = 1'b0;
              short_nxt   = (held_after == HW'(2)) || (seg_count < rbp_pkg::SEG_W'(2));
              state_nxt   = S_PT_RD;
            end
          end
        end
      end
      S_PT_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_PT_OUT;
      end
      S_PT_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = pt_last_r;
          if (pt_last_r) begin
            held_nxt  = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else if (short_r) begin
            pt_addr_nxt = HW'(1);
            pt_last_nxt = 1'b1;
            state_nxt   = S_PT_RD;
          end else begin
            state_nxt = S_BN_INIT;
          end
        end
      end
      S_BN_INIT: begin
        cmd.bn_init = 1'b1;
        s_nxt       = '0;
        state_nxt   = S_BN_STEP;
      end
      S_BN_STEP: begin
        cmd.bn_step = 1'b1;
        s_nxt       = s_r + 1'b1;
        if (s_r == deg - 1'b1) begin
          i_nxt     = rbp_pkg::SEG_W'(1);
          state_nxt = S_T_DIV;
        end
      end
      S_T_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_T_WAIT;
      end
      S_T_WAIT: begin
        if (!status.div_busy) begin
          cmd.res_load = 1'b1;
          cmd.acc_clr  = 1'b1;
          j_nxt        = '0;
          state_nxt    = S_J_RD;
        end
      end
      S_J_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.p_init = 1'b1;
        s_nxt      = '0;
        if (j_r != '0) begin
          state_nxt = S_PT_MUL;
        end else if (deg_left != '0) begin
          state_nxt = S_PU_MUL;
        end else begin
          state_nxt = S_BP_MUL;
        end
      end
      S_PT_MUL: begin
        cmd.mul_sel = rbp_pkg::MUL_PT;
        state_nxt   = S_PT_SH;
      end
      S_PT_SH: begin
        cmd.p_shift = 1'b1;
        if (s_r + 1'b1 == j_r) begin
          s_nxt     = '0;
          state_nxt = (deg_left != '0) ? S_PU_MUL : S_BP_MUL;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = S_PT_MUL;
        end
      end
      S_PU_MUL: begin
        cmd.mul_sel = rbp_pkg::MUL_PU;
        state_nxt   = S_PU_SH;
      end
      S_PU_SH: begin
        cmd.p_shift = 1'b1;
        if (s_r + 1'b1 == deg_left) begin
          s_nxt     = '0;
          state_nxt = S_BP_MUL;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = S_PU_MUL;
        end
      end
      S_BP_MUL: begin
        cmd.mul_sel = rbp_pkg::MUL_BP;
        state_nxt   = S_W_MUL;
      end
      S_W_MUL: begin
        cmd.mul_sel = rbp_pkg::MUL_W;
        state_nxt   = S_C_ACC;
      end
      S_C_ACC: begin
        cmd.acc_sel = rbp_pkg::ACC_DEN;
        state_nxt   = S_X_MUL;
      end
      S_X_MUL: begin
        cmd.mul_sel = rbp_pkg::MUL_X;
        state_nxt   = S_Y_MUL;
      end
      S_Y_MUL: begin
        cmd.acc_sel = rbp_pkg::ACC_NX;
        cmd.mul_sel = rbp_pkg::MUL_Y;
        state_nxt   = S_Z_MUL;
      end
      S_Z_MUL: begin
        cmd.acc_sel = rbp_pkg::ACC_NY;
        cmd.mul_sel = rbp_pkg::MUL_Z;
        state_nxt   = S_Z_ACC;
      end
      S_Z_ACC: begin
        cmd.acc_sel = rbp_pkg::ACC_NZ;
        if (j_r == deg) begin
          cs_nxt    = rbp_pkg::DIV_X;
          state_nxt = S_D_START;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_J_RD;
        end
      end
      S_D_START: begin
        cmd.div_sel   = cs_r;
        cmd.div_start = 1'b1;
        state_nxt     = S_D_WAIT;
      end
      S_D_WAIT: begin
        cmd.div_sel = cs_r;
        if (!status.div_busy) begin
          cmd.res_load = 1'b1;
          unique case (cs_r)
            rbp_pkg::DIV_X: begin
              cs_nxt    = rbp_pkg::DIV_Y;
              state_nxt = S_D_START;
            end
            rbp_pkg::DIV_Y: begin
              cs_nxt    = rbp_pkg::DIV_Z;
              state_nxt = S_D_START;
            end
            default: state_nxt = S_S_OUT;
          endcase
        end
      end
      S_S_OUT: begin
        if (status.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sample = 1'b1;
          if (i_r + 1'b1 == seg_count) begin
            pt_addr_nxt = deg;
            pt_last_nxt = 1'b1;
            state_nxt   = S_PT_RD;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_T_DIV;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      held_r    <= '0;
      ovf_r     <= 1'b0;
      j_r       <= '0;
      s_r       <= '0;
      i_r       <= '0;
      pt_addr_r <= '0;
      pt_last_r <= 1'b0;
      short_r   <= 1'b0;
      cs_r      <= rbp_pkg::DIV_X;
    end else begin
      state_r   <= state_nxt;
      held_r    <= held_nxt;
      ovf_r     <= ovf_nxt;
      j_r       <= j_nxt;
      s_r       <= s_nxt;
      i_r       <= i_nxt;
      pt_addr_r <= pt_addr_nxt;
      pt_last_r <= pt_last_nxt;
      short_r   <= short_nxt;
      cs_r      <= cs_nxt;
    end
  end

  `RBP_ASSERT(a_held_bound, held_r <= HW'(MAX_POINTS), "point count exceeds store depth")
  `RBP_NEVER(a_div_overrun, cmd.div_start && status.div_busy, "divider restarted while busy")
  `RBP_NEVER(a_out_overrun, cmd.out_load && !status.out_free, "output item overwritten")
  `RBP_ASSERT(a_plot_clears, (state_r == S_PT_OUT && pt_last_r && status.out_free) |=> (held_r == '0 && !ovf_r), "store not emptied after plot")
endmodule
`default_nettype wire

@@ hw/rtl/rational_bezier_plotter.sv @@
// Rational Bezier plotter top level: stream channels, register port, controller and datapath.
//
// Input channel: one weighted control point per item, taken one per cycle while
// the block is loading. in_tlast marks the final point and starts the plot; no
// item is accepted until the last point of that curve sits in the output register.
// Points beyond MAX_POINTS are dropped and reported on out_tuser. A lone point plots nothing.
// Output channel: first point, segment_count-1 interior samples, last point; with two
// points or a segment_count below 2, only the first and last point. out_tlast marks
// the last one. Held points are given straight from the store. For each interior
// sample the power terms iterate on one shared multiplier, and the t value and the
// three coordinate quotients each pass through a one bit per cycle divider of 64
// steps. A held point is given by a store read and then the output load, and the
// binomial row of a curve is built after its first point has been output.
// The output item sits in a register; while the receiver stalls the plot pauses
// at the next sample. Reset empties the store and sets segment_count to 16.
// The configuration register (segment_count, address 0) is read and written
// through the APB port and should be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module rational_bezier_plotter #(
  parameter int MAX_POINTS = rbp_pkg::MAX_POINTS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,   // x_coord, y_coord, z_coord, weight
  input  wire logic         in_tlast,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,  // out_x, out_y, out_z
  output logic              out_tlast,
  output logic              out_tuser,  // truncated
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [2:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = rbp_pkg::COORD_W;

  logic [rbp_pkg::SEG_W-1:0] seg_r;
  rbp_pkg::cmd_t             cmd;
  rbp_pkg::status_t          status;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [CW-1:0]             res_x, res_y, res_z;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r <= rbp_pkg::SEG_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      seg_r <= cfg_pwdata[rbp_pkg::SEG_W-1:0];
    end
  end

  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {26'd0, seg_r};

  rbp_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_last   (in_tlast),
    .seg_count (seg_r),
    .status    (status),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  rbp_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr),
    .status    (status),
    .seg_count (seg_r),
    .in_x      (in_tdata[31:0]),
    .in_y      (in_tdata[63:32]),
    .in_z      (in_tdata[95:64]),
    .in_w      (in_tdata[111:96]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_x     (res_x),
    .out_y     (res_y),
    .out_z     (res_z),
    .out_last  (out_tlast),
    .out_trunc (out_tuser)
  );

  assign out_tdata = {res_z, res_y, res_x};
endmodule
`default_nettype wire

@@ verif/tb_rational_bezier_plotter.sv @@
// Self-checking testbench of the rational Bezier plotter: streams control points, predicts samples.
`timescale 1ns / 1ps
module tb_rational_bezier_plotter;
  localparam int CAPACITY   = rbp_pkg::MAX_POINTS_DEF;
  localparam int CYCLE_CAP  = 1500000;
  localparam int DRAIN_WAIT = 100;
  localparam logic [2:0] SEG_ADDR  = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
    logic        trunc;
  } sample_t;

  typedef struct {
    logic [31:0] x, y, z;
    logic [15:0] w;
    bit          last;
    int          n_exp;     // typed result count, -1 where the predictor decides
    logic [31:0] ex, ey, ez; // typed first result, used where n_exp > 0
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [111:0] in_tdata = '0;  // x_coord, y_coord, z_coord, weight
  logic         in_tlast = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;      // out_x, out_y, out_z
  logic         out_tlast;
  logic         out_tuser;      // truncated
  logic         cfg_psel = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite = 1'b0;
  logic [2:0]   cfg_paddr = '0;
  logic [31:0]  cfg_pwdata = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  rational_bezier_plotter i_dut (.*);

  always #2 clk = ~clk;

  // Predictor state
  longint      held_x[CAPACITY], held_y[CAPACITY], held_z[CAPACITY];
  longint      held_w[CAPACITY];
  int          n_held = 0;
  bit          dropped = 1'b0;
  int          seg_count = 16;
  sample_t     sample_q[$];

  int          errors = 0;
  int          cycles = 0;
  int          n_points = 0;
  int          n_samples = 0;
  int          n_curves = 0;
  int          snd_idle_pct = 0;
  int          rcv_stall_pct = 0;
  stim_row_t   rows[$];

  function automatic void queue_sample(longint x, longint y, longint z, bit last);
    sample_t s;
    s.x = x[31:0];
    s.y = y[31:0];
    s.z = z[31:0];
    s.last = last;
    s.trunc = dropped;
    sample_q.insert(sample_q.size(), s);
  endfunction

  function automatic void plot_curve();
    longint t, u, binom, p, c, den, nx, ny, nz;
    int d;
    if (n_held < 2) return;
    n_curves++;
    if (n_held == 2 || seg_count < 2) begin
      queue_sample(held_x[0], held_y[0], held_z[0], 1'b0);
      queue_sample(held_x[1], held_y[1], held_z[1], 1'b1);
      return;
    end
    d = n_held - 1;
    queue_sample(held_x[0], held_y[0], held_z[0], 1'b0);
    for (int i = 1; i < seg_count; i++) begin
      t = (longint'(i) << 16) / seg_count;
      u = 65536 - t;
      binom = 1;
      den = 0; nx = 0; ny = 0; nz = 0;
      for (int j = 0; j <= d; j++) begin
        p = 65536;
        for (int s = 0; s < j; s++) p = (p * t) >>> 16;
        for (int s = 0; s < d - j; s++) p = (p * u) >>> 16;
        c = binom * p * held_w[j];
        den += c;
        nx += held_x[j] * c;
        ny += held_y[j] * c;
        nz += held_z[j] * c;
        binom = binom * (d - j) / (j + 1);
      end
      if (den > 0) queue_sample(nx / den, ny / den, nz / den, 1'b0);
      else queue_sample(0, 0, 0, 1'b0);
    end
    queue_sample(held_x[d], held_y[d], held_z[d], 1'b1);
  endfunction

  function automatic void accept_point(logic [31:0] x, y, z, logic [15:0] w, bit last);
    if (n_held < CAPACITY) begin
      held_x[n_held] = longint'($signed(x));
      held_y[n_held] = longint'($signed(y));
      held_z[n_held] = longint'($signed(z));
      held_w[n_held] = longint'(w);
      n_held++;
    end else begin
      dropped = 1'b1;
    end
    if (last) begin
      plot_curve();
      n_held = 0;
      dropped = 1'b0;
    end
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= rcv_stall_pct);

  // Sample checker
  always @(posedge clk) begin
    sample_t exp_s;
    if (rst_n && out_tvalid && out_tready) begin
      if (sample_q.size() == 0) begin
        $error("unexpected sample x=%h y=%h z=%h", out_tdata[31:0], out_tdata[63:32],
               out_tdata[95:64]);
        errors++;
      end else begin
        exp_s = sample_q.pop_front();
        n_samples++;
        if (out_tdata[31:0] !== exp_s.x) begin
          $error("out_x expected %h got %h", exp_s.x, out_tdata[31:0]); errors++;
        end
        if (out_tdata[63:32] !== exp_s.y) begin
          $error("out_y expected %h got %h", exp_s.y, out_tdata[63:32]); errors++;
        end
        if (out_tdata[95:64] !== exp_s.z) begin
          $error("out_z expected %h got %h", exp_s.z, out_tdata[95:64]); errors++;
        end
        if (out_tlast !== exp_s.last) begin
          $error("last_sample expected %0d got %0d", exp_s.last, out_tlast); errors++;
        end
        if (out_tuser !== exp_s.trunc) begin
          $error("truncated expected %0d got %0d", exp_s.trunc, out_tuser); errors++;
        end
      end
    end
  end

  task automatic cfg_access(logic [2:0] addr, logic [31:0] data, bit wr);
    @(negedge clk);
    cfg_psel <= 1'b1; cfg_pwrite <= wr; cfg_paddr <= addr; cfg_pwdata <= data;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (!wr && cfg_prdata !== {26'b0, seg_count[5:0]}) begin
      $error("segment_count read expected %0d got %0d", seg_count, cfg_prdata);
      errors++;
    end
    if (wr && addr == SEG_ADDR) seg_count = int'(data[5:0]);
    @(negedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (sample_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, y, z, logic [15:0] w, bit last);
    while ($urandom_range(99) < snd_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {w, z, y, x};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    accept_point(x, y, z, w, last);
    n_points++;
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(131071) - 65536;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_weight();
    case ($urandom_range(7))
      0: return 16'd1;
      1: return 16'hFFFF;
      2: return 16'h0100;
      default: return $urandom_range(65535, 1);
    endcase
  endfunction

  function automatic void add_row(logic [31:0] x, y, z, logic [15:0] w, bit last,
                                  int n_exp);
    stim_row_t r;
    r.x = x; r.y = y; r.z = z; r.w = w; r.last = last; r.n_exp = n_exp;
    r.ex = x; r.ey = y; r.ez = z;
    rows.insert(rows.size(), r);
  endfunction

  initial begin
    int mode_of[6] = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER,
                       IDLE_RECEIVER};
    logic [31:0] seg_of[6] = '{32'd16, 32'd0, 32'd1, 32'd63, 32'hFFFF_FF82, 32'd7};
    int left, len, before_n;
    idle_mode_t mode;

    // A single point plots nothing; two points come back as they are.
    add_row(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 16'h0100, 1'b1, 0);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 16'd1, 1'b0, -1);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 2);
    rows[2].ex = rows[1].x; rows[2].ey = rows[1].y; rows[2].ez = rows[1].z;
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b0, -1);
    add_row(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 16'd1, 1'b0, -1);
    add_row(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1, 17);
    rows[5].ex = rows[3].x; rows[5].ey = rows[3].y; rows[5].ez = rows[3].z;
    // Seventeen points: sixteen fill the store and one more is dropped.
    for (int k = 0; k < 17; k++)
      add_row(32'(k) << 16, -(32'(k) << 15), 32'(k * 3), 16'(k * 4000 + 1), k == 16, -1);

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    cfg_access(SEG_ADDR, 32'd0, 1'b0);

    foreach (rows[r]) begin
      before_n = sample_q.size();
      send_point(rows[r].x, rows[r].y, rows[r].z, rows[r].w, rows[r].last);
      if (rows[r].n_exp >= 0 && sample_q.size() - before_n != rows[r].n_exp) begin
        $error("row %0d: result count expected %0d got %0d", r, rows[r].n_exp,
               sample_q.size() - before_n);
        errors++;
      end
      if (rows[r].n_exp > 0 && {sample_q[before_n].x, sample_q[before_n].y,
          sample_q[before_n].z} !== {rows[r].ex, rows[r].ey, rows[r].ez}) begin
        $error("row %0d: first sample expected %h %h %h", r, rows[r].ex, rows[r].ey,
               rows[r].ez);
        errors++;
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      wait_quiet();
      if (ph == 3) cfg_access(SPARE_ADDR, 32'h0000_0015, 1'b1);
      cfg_access(SEG_ADDR, seg_of[ph], 1'b1);
      cfg_access(SEG_ADDR, 32'd0, 1'b0);
      mode = idle_mode_t'(mode_of[ph]);
      snd_idle_pct  = (mode == IDLE_SENDER) ? 65 : (mode == IDLE_BOTH) ? 16 : 0;
      rcv_stall_pct = (mode == IDLE_RECEIVER) ? 65 : (mode == IDLE_BOTH) ? 16 : 0;
      left = 26;
      while (left > 0) begin
        len = $urandom_range(5, 1);
        // Long curves only where few samples are drawn, so the run stays short.
        if (seg_count <= 8 && $urandom_range(7) == 0) len = $urandom_range(18, 14);
        if (len > left) len = left;
        if (ph == 2 && left < 15) begin
          while (sample_q.size() != 0) @(posedge clk);
        end
        for (int k = 0; k < len; k++)
          send_point(rand_coord(), rand_coord(), rand_coord(), rand_weight(), k == len - 1);
        left -= len;
      end
      @(negedge clk);
      in_tvalid <= 1'b0;
    end

    wait_quiet();
    $display("Covered %0d control points in %0d curves, %0d samples checked,", n_points,
             n_curves, n_samples);
    $display("segment counts 0, 1, 2, 7, 16 and 63, with sender and receiver stalls.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
